>>> design/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants of the contiguous block allocator
// Request/response codes, the bitmap word size and controller/datapath links.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int          MAX_BLOCKS_DEF  = 256;
    localparam int          WORD_BITS       = 8;
    localparam logic [8:0]  DISK_BLOCKS_RST = 9'd256;

    typedef enum logic {
        OP_MARK  = 1'b0,
        OP_ALLOC = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_MARKED    = 2'd2
    } t_status;

    typedef struct packed {
        logic    clr;
        logic    take;
        logic    chk;
        logic    scan_first;
        logic    scan;
        logic    mark_first;
        logic    mark;
        logic    load;
        t_status res;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic req_alloc;
        logic req_bad;
        logic found;
        logic scan_last;
        logic mark_last;
        logic out_free;
    } t_sts;

endpackage

>>> design/cba_req_if.sv
// ----------------------------------------------------------------------------
// cba_req_if: request channel
// Carries one mark or allocate request per transaction.
// ----------------------------------------------------------------------------
interface cba_req_if import cba_pkg::*; ();

    logic       valid;
    logic       ready;
    t_op        op;
    logic [7:0] start_block;
    logic [8:0] block_count;

    modport source (output valid, output op, output start_block, output block_count,
                    input ready);
    modport sink   (input valid, input op, input start_block, input block_count,
                    output ready);

endinterface

>>> design/cba_rsp_if.sv
// ----------------------------------------------------------------------------
// cba_rsp_if: response channel
// Carries one status and block range per transaction.
// ----------------------------------------------------------------------------
interface cba_rsp_if import cba_pkg::*; ();

    logic       valid;
    logic       ready;
    t_status    status;
    logic [7:0] first_block;
    logic [7:0] last_block;

    modport source (output valid, output status, output first_block, output last_block,
                    input ready);
    modport sink   (input valid, input status, input first_block, input last_block,
                    output ready);

endinterface

>>> design/cba_ctrl.sv
// ----------------------------------------------------------------------------
// cba_ctrl: allocator controller
// Sequences bitmap clear, request check, first-fit scan and run marking.
// ----------------------------------------------------------------------------
module cba_ctrl import cba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN_FIRST,
        S_SCAN,
        S_MARK_FIRST,
        S_MARK,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    t_status r_res, n_res;

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        o_cmd     = '0;
        o_cmd.res = r_res;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.req_bad) begin
                    n_res   = ST_NO_SPACE;
                    n_state = S_FINISH;
                end else if (i_sts.req_alloc) begin
                    n_state = S_SCAN_FIRST;
                end else begin
                    n_state = S_MARK_FIRST;
                end
            end
            S_SCAN_FIRST: begin
                o_cmd.scan_first = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_MARK_FIRST;
                end else if (i_sts.scan_last) begin
                    n_res   = ST_NO_SPACE;
                    n_state = S_FINISH;
                end
            end
            S_MARK_FIRST: begin
                o_cmd.mark_first = 1'b1;
                n_state          = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_sts.mark_last) begin
                    n_res   = i_sts.req_alloc ? ST_ALLOCATED : ST_MARKED;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_res   <= ST_NO_SPACE;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

>>> design/cba_dpath.sv
// ----------------------------------------------------------------------------
// cba_dpath: allocator datapath
// Used-block bitmap memory, request registers, word-wide run scan and marking,
// response register.
// ----------------------------------------------------------------------------
module cba_dpath import cba_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    input  t_op        i_req_op,
    input  logic [7:0] i_req_start,
    input  logic [8:0] i_req_count,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output t_status    o_rsp_status,
    output logic [7:0] o_rsp_first,
    output logic [7:0] o_rsp_last
);

    localparam int NW = MAX_BLOCKS / WORD_BITS;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int WL = $clog2(WORD_BITS);
    localparam int SW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = (SW > 9) ? SW : 9;

    typedef logic [XW-1:0] t_blk;

    logic [WORD_BITS-1:0] r_mem [NW];
    logic [WORD_BITS-1:0] r_rdata;
    logic [8:0]           r_disk_blocks;
    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_cur_w;
    t_op                  r_op;
    t_blk                 r_start;
    t_blk                 r_count;
    t_blk                 r_len;
    t_blk                 r_rs;
    t_blk                 r_run_first;
    t_blk                 r_run_last;
    logic                 r_rsp_valid;
    t_status              r_rsp_status;
    logic [7:0]           r_rsp_first;
    logic [7:0]           r_rsp_last;

    t_blk                 size;
    t_blk                 disk_x;
    t_blk                 len;
    t_blk                 rs;
    logic                 fnd;
    logic [WORD_BITS-1:0] mask;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        scan_last_w;

    assign disk_x = t_blk'(r_disk_blocks);
    assign size   = (disk_x > t_blk'(MAX_BLOCKS)) ? t_blk'(MAX_BLOCKS) : disk_x;

    // first-fit step over one bitmap word
    always_comb begin
        t_blk b;
        b   = '0;
        len = r_len;
        rs  = r_rs;
        fnd = 1'b0;
        for (int i = 0; i < WORD_BITS; i++) begin
            b = (t_blk'(r_cur_w) << WL) | t_blk'(i);
            if (!fnd && (b >= r_start) && (b < size)) begin
                if (r_rdata[i]) begin
                    len = '0;
                    rs  = b + t_blk'(1);
                end else begin
                    len = len + t_blk'(1);
                    if (len == r_count) begin
                        fnd = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        t_blk b;
        b = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            b       = (t_blk'(r_cur_w) << WL) | t_blk'(j);
            mask[j] = (b >= r_run_first) && (b <= r_run_last);
        end
    end

    assign rd_en   = i_cmd.scan_first | i_cmd.scan | i_cmd.mark_first | i_cmd.mark;
    assign rd_addr = i_cmd.scan_first ? r_start[WL +: AW] :
                     i_cmd.mark_first ? r_run_first[WL +: AW] :
                                        r_cur_w + AW'(1);
    assign wr_en   = i_cmd.clr | i_cmd.mark;
    assign wr_addr = i_cmd.clr ? r_clr_addr : r_cur_w;
    assign wr_data = i_cmd.clr ? '0 : (r_rdata | mask);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_cur_w <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_blocks <= DISK_BLOCKS_RST;
            r_clr_addr    <= '0;
            r_rsp_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_disk_blocks <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= i_req_op;
            r_start <= t_blk'(i_req_start);
            r_count <= t_blk'(i_req_count);
        end
        if (i_cmd.chk) begin
            r_len       <= '0;
            r_rs        <= r_start;
            r_run_first <= r_start;
            r_run_last  <= r_start;
        end
        if (i_cmd.scan) begin
            r_len <= len;
            r_rs  <= rs;
            if (fnd) begin
                r_run_first <= rs;
                r_run_last  <= rs + r_count - t_blk'(1);
            end
        end
        if (i_cmd.load) begin
            r_rsp_status <= i_cmd.res;
            case (i_cmd.res)
                ST_NO_SPACE: begin
                    r_rsp_first <= '0;
                    r_rsp_last  <= '0;
                end
                default: begin
                    r_rsp_first <= r_run_first[7:0];
                    r_rsp_last  <= r_run_last[7:0];
                end
            endcase
        end
    end

    assign scan_last_w = AW'(t_blk'(size - t_blk'(1)) >> WL);

    always_comb begin
        o_sts.clr_done  = (r_clr_addr == AW'(NW - 1));
        o_sts.req_alloc = (r_op == OP_ALLOC);
        if (r_op == OP_ALLOC) begin
            o_sts.req_bad = (r_count == '0) || (r_start >= size) || (r_count > size - r_start);
        end else begin
            o_sts.req_bad = (r_start >= size);
        end
        o_sts.found     = fnd;
        o_sts.scan_last = (r_cur_w == scan_last_w);
        o_sts.mark_last = (r_cur_w == r_run_last[WL +: AW]);
        o_sts.out_free  = !r_rsp_valid || i_rsp_ready;
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_rsp_status = r_rsp_status;
    assign o_rsp_first  = r_rsp_first;
    assign o_rsp_last   = r_rsp_last;

endmodule

>>> design/contiguous_block_allocator_core.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core: first-fit contiguous block allocator
// Request to response: a mark passes check, marking and finish; an allocate passes check,
// a first-fit scan of bitmap words (8 blocks each), marking and finish; a failed scan or a
// rejected request goes to finish. One request at a time; a held response stalls the next.
// Reset: bitmap clear pass over all MAX_BLOCKS/8 words, request ready low meanwhile;
// disk_blocks resets to 256.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_core import cba_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    cba_req_if.sink    i_req,
    cba_rsp_if.source  o_rsp
);

    t_cmd cmd;
    t_sts sts;

    cba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_op     (i_req.op),
        .i_req_start  (i_req.start_block),
        .i_req_count  (i_req.block_count),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_status (o_rsp.status),
        .o_rsp_first  (o_rsp.first_block),
        .o_rsp_last   (o_rsp.last_block)
    );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of contiguous_block_allocator_core
// A queue of requests feeds a clocked driver, and a clocked monitor predicts
// each accepted request with a bitmap of its own and checks the responses in
// order. Directed requests come first, then random phases over disk sizes
// with different idle patterns, a long response hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb;
    import cba_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 155;

    typedef struct {
        t_op        op;
        logic [7:0] start_block;
        logic [8:0] block_count;
    } t_request;

    typedef struct {
        t_status    status;
        logic [7:0] first_block;
        logic [7:0] last_block;
    } t_reply;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [8:0] i_cfg_wdata;

    cba_req_if req_if ();
    cba_rsp_if rsp_if ();

    contiguous_block_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    t_request    request_q[$];
    t_reply      predicted_replies[$];
    bit          block_used[MAX_BLOCKS_DEF];
    int unsigned disk_size;
    int unsigned req_pushed;
    int unsigned req_accepted;
    int unsigned mismatches;
    int unsigned sender_idle_pct;
    int unsigned rsp_stall_pct;
    int unsigned rsp_holdoff;
    int unsigned quiet_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_reply predict_allocation(t_request r);
        t_reply      res;
        int unsigned size;
        int unsigned run_start;
        int unsigned run_len;
        bit          found;
        size = (disk_size > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : disk_size;
        res.status      = ST_NO_SPACE;
        res.first_block = '0;
        res.last_block  = '0;
        found     = 1'b0;
        run_start = 32'(r.start_block);
        run_len   = 0;
        if (r.op == OP_MARK) begin
            if (r.start_block < size) begin
                block_used[r.start_block] = 1'b1;
                res.status      = ST_MARKED;
                res.first_block = r.start_block;
                res.last_block  = r.start_block;
            end
            return res;
        end
        if (r.block_count == 0 || r.start_block >= size || r.block_count > size - r.start_block)
            return res;
        for (int b = int'(r.start_block); b < size && !found; b++) begin
            if (block_used[b]) begin
                run_len   = 0;
                run_start = b + 1;
            end else begin
                run_len++;
                if (run_len == r.block_count)
                    found = 1'b1;
            end
        end
        if (found) begin
            for (int b = run_start; b < run_start + r.block_count; b++)
                block_used[b] = 1'b1;
            res.status      = ST_ALLOCATED;
            res.first_block = 8'(run_start);
            res.last_block  = 8'(run_start + r.block_count - 1);
        end
        return res;
    endfunction

    function automatic t_request random_request(int unsigned size);
        t_request    r;
        int unsigned pick;
        int unsigned span;
        span = (size == 0) ? 1 : ((size > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : size);
        r.op = ($urandom_range(99) < 20) ? OP_MARK : OP_ALLOC;
        pick = $urandom_range(99);
        if (pick < 10)
            r.start_block = 8'($urandom_range(255));
        else if (r.op == OP_ALLOC && pick < 55)
            r.start_block = 8'($urandom_range((span - 1) / 2));
        else
            r.start_block = 8'($urandom_range(span - 1));
        pick = $urandom_range(99);
        if (pick < 65)
            r.block_count = 9'($urandom_range(4, 1));
        else if (pick < 88)
            r.block_count = 9'($urandom_range(24, 1));
        else if (pick < 97)
            r.block_count = 9'($urandom_range(511));
        else
            r.block_count = '0;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_request r;
        if (!(req_if.valid && !req_if.ready)) begin
            if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                r = request_q.pop_front();
                req_if.valid       <= 1'b1;
                req_if.op          <= r.op;
                req_if.start_block <= r.start_block;
                req_if.block_count <= r.block_count;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_request r;
        t_reply   exp_reply;
        if (rsp_holdoff > 0) begin
            rsp_holdoff  = rsp_holdoff - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end

        if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_replies.size() == 0) begin
                $error("response with no request outstanding: status %0d first %0d last %0d",
                       rsp_if.status, rsp_if.first_block, rsp_if.last_block);
                mismatches++;
            end else begin
                exp_reply = predicted_replies.pop_front();
                if (rsp_if.status !== exp_reply.status) begin
                    $error("status: expected %0d, actual %0d", exp_reply.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.first_block !== exp_reply.first_block) begin
                    $error("first_block: expected %0d, actual %0d",
                           exp_reply.first_block, rsp_if.first_block);
                    mismatches++;
                end
                if (rsp_if.last_block !== exp_reply.last_block) begin
                    $error("last_block: expected %0d, actual %0d",
                           exp_reply.last_block, rsp_if.last_block);
                    mismatches++;
                end
            end
        end

        if (req_if.valid && req_if.ready) begin
            r.op          = req_if.op;
            r.start_block = req_if.start_block;
            r.block_count = req_if.block_count;
            predicted_replies.push_back(predict_allocation(r));
            req_accepted++;
        end

        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_request(t_op op, int unsigned start, int unsigned count);
        t_request r;
        r.op          = op;
        r.start_block = 8'(start);
        r.block_count = 9'(count);
        request_q.push_back(r);
        req_pushed++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (!(req_accepted == req_pushed && predicted_replies.size() == 0));
    endtask

    task automatic write_disk_blocks(int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 9'(value);
        disk_size = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_idle_mode(int unsigned mode);
        case (mode % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin sender_idle_pct = 19; rsp_stall_pct = 19; end
        endcase
    endtask

    initial begin
        int unsigned phase_sizes[9];
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_if.valid       = 1'b0;
        req_if.op          = OP_MARK;
        req_if.start_block = '0;
        req_if.block_count = '0;
        rsp_if.ready       = 1'b0;
        disk_size          = 32'(DISK_BLOCKS_RST);
        req_pushed         = 0;
        req_accepted       = 0;
        mismatches         = 0;
        rsp_holdoff        = 0;
        quiet_cycles       = 0;
        set_idle_mode(0);
        phase_sizes = '{32, 64, 0, 128, 1, 200, 256, 511, 300};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // small disk: repeated mark, out-of-range mark, zero count, bounds, fragment fit
        write_disk_blocks(16);
        push_request(OP_MARK, 0, 0);
        push_request(OP_MARK, 0, 511);
        push_request(OP_MARK, 20, 1);
        push_request(OP_ALLOC, 0, 0);
        push_request(OP_ALLOC, 0, 3);
        push_request(OP_ALLOC, 15, 2);
        push_request(OP_ALLOC, 16, 1);
        push_request(OP_ALLOC, 5, 11);
        push_request(OP_ALLOC, 0, 1);
        push_request(OP_ALLOC, 0, 1);
        wait_drained();

        write_disk_blocks(0);
        push_request(OP_MARK, 0, 1);
        push_request(OP_ALLOC, 0, 1);
        wait_drained();

        write_disk_blocks(1);
        push_request(OP_ALLOC, 0, 1);
        push_request(OP_ALLOC, 0, 1);
        wait_drained();

        // oversize disk saturates at the bitmap size
        write_disk_blocks(511);
        push_request(OP_MARK, 255, 256);
        push_request(OP_ALLOC, 255, 1);
        push_request(OP_ALLOC, 200, 256);
        push_request(OP_ALLOC, 250, 5);
        push_request(OP_ALLOC, 0, 511);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            write_disk_blocks(phase_sizes[p]);
            set_idle_mode(p);
            if (p == 2)
                rsp_holdoff = 300;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                push_request(OP_ALLOC, 0, 0);
                request_q[request_q.size() - 1] = random_request(disk_size);
            end
            wait_drained();
        end

        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
        if (predicted_replies.size() != 0) begin
            $error("%0d responses never arrived", predicted_replies.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
